@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/dmm_pkg.sv @@
// Package for the dense matrix multiply unit: word types, command type,
// opcodes, back-end states and sizing constants. No dependencies.
package dmm_pkg;

   localparam int MAX_DIM_DEFAULT = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int IDX_W           = 4;
   localparam int DIM_W           = 5;
   localparam int VAL_W           = 16;
   localparam int PROD_W          = 32;
   localparam int ACC_W           = 40;
   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   typedef enum logic [0:0] {
      OP_B_WRITE = 1'b0,
      OP_A_ELEM  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MAC,
      BK_DRAIN,
      BK_EMIT
   } bk_state_type;

   typedef struct packed {
      logic                    opcode;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [VAL_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [ACC_W-1:0] product_sum;
      logic                    last;
   } rsp_word_type;

   typedef struct packed {
      op_type                  kind;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
      logic                    clear;
      logic                    emit;
      logic [DIM_W-1:0]        dim;
   } cmd_type;

endpackage

@@ design/dmm_front.sv @@
// Front end: dimension register, input acceptance and classification.
// Depends on dmm_pkg; feeds dmm_queue.
module dmm_front
   import dmm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DIM_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   input  req_word_type      req_word,
   output logic              req_stall,
   input  logic              q_full,
   output logic              push,
   output cmd_type           push_cmd
);

   localparam int DIM_CAP = (MAX_DIM > 31) ? 31 : MAX_DIM;

   logic [DIM_W-1:0] dim_ff, dim_in;
   logic [DIM_W-1:0] dim_eff;
   logic             keep;

   always_comb begin
      dim_in = csr_wr_en ? csr_wr_data : dim_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else begin
         dim_ff <= dim_in;
      end
   end

   always_comb begin
      if (dim_ff == '0) begin
         dim_eff = DIM_W'(1);
      end else if (32'(dim_ff) > DIM_CAP) begin
         dim_eff = DIM_W'(DIM_CAP);
      end else begin
         dim_eff = dim_ff;
      end
   end

   always_comb begin
      push_cmd.kind  = op_type'(req_word.opcode);
      push_cmd.row   = req_word.row_index;
      push_cmd.col   = req_word.col_index;
      push_cmd.value = req_word.value;
      push_cmd.clear = (req_word.col_index == '0);
      push_cmd.emit  = (DIM_W'(req_word.col_index) == dim_eff - DIM_W'(1));
      push_cmd.dim   = dim_eff;
      unique case (op_type'(req_word.opcode))
         OP_B_WRITE: keep = (32'(req_word.row_index) < MAX_DIM) &&
                            (32'(req_word.col_index) < MAX_DIM);
         OP_A_ELEM:  keep = (DIM_W'(req_word.col_index) < dim_eff);
         default:    keep = 1'b0;
      endcase
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full && keep;

endmodule

@@ design/dmm_queue.sv @@
// Short command queue between front and back ends.
// Depends on dmm_pkg for the command type.
module dmm_queue
   import dmm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (32'(count_ff) == QUEUE_DEPTH);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/dmm_back.sv @@
// Back end: B store, shared multiply-accumulate loop over columns,
// column accumulators and the result word register. Depends on dmm_pkg.
module dmm_back
   import dmm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      head,
   input  logic         q_empty,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         rsp_stall
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int J_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic signed [VAL_W-1:0]  b_mem [DEPTH];
   logic signed [ACC_W-1:0]  acc_ff [MAX_DIM];

   bk_state_type             state_ff, state_in;
   cmd_type                  cur_ff, cur_in;
   logic [DIM_W-1:0]         j_ff, j_in;
   logic [DIM_W-1:0]         e_ff, e_in;
   logic                     s1_vld_ff, s2_vld_ff;
   logic [DIM_W-1:0]         s1_j_ff, s2_j_ff;
   logic signed [VAL_W-1:0]  b_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     rsp_vld_ff, rsp_vld_in;
   rsp_word_type             rsp_ff, rsp_in;

   logic                     mem_wr, issue, load;
   logic                     j_last, e_last;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;
   logic [J_W-1:0]           acc_idx;
   logic signed [ACC_W-1:0]  acc_rd, acc_base;

   assign j_last  = (j_ff == cur_ff.dim - DIM_W'(1));
   assign e_last  = (e_ff == cur_ff.dim - DIM_W'(1));
   assign load    = !rsp_vld_ff || !rsp_stall;
   assign wr_addr = ADDR_W'(ADDR_W'(head.row) * MAX_DIM + ADDR_W'(head.col));
   assign rd_addr = ADDR_W'(ADDR_W'(cur_ff.col) * MAX_DIM + ADDR_W'(j_ff));
   assign acc_idx = J_W'((state_ff == BK_EMIT) ? e_ff : s2_j_ff);
   assign acc_rd  = acc_ff[acc_idx];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && head.kind == OP_A_ELEM) begin
               state_in = BK_MAC;
            end
         end
         BK_MAC: begin
            if (j_last) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = cur_ff.emit ? BK_EMIT : BK_IDLE;
            end
         end
         BK_EMIT: begin
            if (load && e_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop    = 1'b0;
      mem_wr = 1'b0;
      issue  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop    = !q_empty;
            mem_wr = !q_empty && (head.kind == OP_B_WRITE);
         end
         BK_MAC:   issue = 1'b1;
         BK_DRAIN: issue = 1'b0;
         BK_EMIT:  issue = 1'b0;
         default:  issue = 1'b0;
      endcase
   end

   always_comb begin
      cur_in = (pop) ? head : cur_ff;
      j_in   = pop ? '0 : (issue ? j_ff + DIM_W'(1) : j_ff);
      e_in   = pop ? '0 : ((state_ff == BK_EMIT && load) ? e_ff + DIM_W'(1) : e_ff);
      rsp_in             = rsp_ff;
      rsp_in.out_row     = cur_ff.row;
      rsp_in.out_col     = IDX_W'(e_ff);
      rsp_in.product_sum = acc_rd;
      rsp_in.last        = e_last;
      rsp_vld_in = (state_ff == BK_EMIT) ? 1'b1 : (rsp_vld_ff && rsp_stall);
      acc_base   = cur_ff.clear ? '0 : acc_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         s1_vld_ff  <= issue;
         s2_vld_ff  <= s1_vld_ff;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      j_ff    <= j_in;
      e_ff    <= e_in;
      s1_j_ff <= j_ff;
      s2_j_ff <= s1_j_ff;
      prod_ff <= cur_ff.value * b_rd_ff;
      if (state_ff == BK_EMIT && load) begin
         rsp_ff <= rsp_in;
      end
      if (s2_vld_ff) begin
         acc_ff[acc_idx] <= acc_base + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         b_mem[wr_addr] <= head.value;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_rd_ff <= b_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_ff;

endmodule

@@ design/dense_matrix_multiply_unit.sv @@
// Dense matrix multiply unit, C = A x B with B stationary.
// B write: one store write in the back end. A element: one B read and
// one multiply per column through the single MAC unit, then a pipeline drain;
// the element that ends a row adds dim result words, one per cycle when
// rsp_stall is low. Synchronous reset clears control state and sets the dim
// register to 16; the B store and accumulators keep their contents.
module dense_matrix_multiply_unit
   import dmm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [DIM_W-1:0] csr_wr_data,
   input  logic             req_valid,
   input  req_word_type     req_word,
   output logic             req_stall,
   output logic             rsp_valid,
   output rsp_word_type     rsp_word,
   input  logic             rsp_stall
);

   logic    push, pop, q_empty, q_full;
   cmd_type push_cmd, head;

   dmm_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_word    (req_word),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   dmm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   dmm_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

endmodule

@@ design/dmm_checker.sv @@
// Port-level checks for the dense matrix multiply unit, bound to the top.
// Depends on dmm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmm_checker
   import dmm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   `ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result word valid after reset")
   `ASSERT_RUN(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled result word changed")
   `ASSERT_RUN(a_row_burst, rsp_valid && !rsp_stall && !rsp_word.last |=> rsp_valid && rsp_word.out_row == $past(rsp_word.out_row), "gap or row change inside a row")
   `ASSERT_RUN(a_col_step, rsp_valid && !rsp_stall && !rsp_word.last |=> rsp_word.out_col == 4'($past(rsp_word.out_col) + 4'd1), "column order broken")
   `ASSERT_RUN(a_row_end, rsp_valid && !rsp_stall && rsp_word.last |=> !rsp_valid || rsp_word.out_col == '0, "next row does not start at column zero")

endmodule

bind dense_matrix_multiply_unit dmm_checker u_dmm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
